// ===== rtl/vct_pkg.sv =====
// ----------------------------------------------------------------------------
// vct_pkg: shared types and constants for the vertex clip transform
// Binary32 constants, item payload types, coefficient storage view, and the
// pipeline geometry used by the front, queue and back parts.
// ----------------------------------------------------------------------------
package vct_pkg;

	localparam int WORD_W       = 32;
	localparam int NUM_MAT      = 16;
	localparam int NUM_LIGHT    = 3;
	localparam int IDX_W        = 5;
	localparam int EXP_W        = 12;
	localparam int FMA_LAT      = 6;
	localparam int NUM_LEVELS   = 8;
	localparam int PIPE_DEPTH   = FMA_LAT * NUM_LEVELS;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam logic [IDX_W-1:0] IDX_LIGHT_BASE = IDX_W'(NUM_MAT);
	localparam logic [IDX_W-1:0] IDX_END        = IDX_W'(NUM_MAT + NUM_LIGHT);

	typedef logic [WORD_W-1:0] f32_t;

	localparam f32_t F32_ONE      = 32'h3F80_0000;
	localparam f32_t F32_NEG_ONE  = 32'hBF80_0000;
	localparam f32_t F32_HALF     = 32'h3F00_0000;
	localparam f32_t F32_NEG_ZERO = 32'h8000_0000;
	localparam f32_t F32_QNAN     = 32'h7FC0_0000;
	localparam f32_t F32_INF      = 32'h7F80_0000;
	localparam f32_t F32_SIGN     = 32'h8000_0000;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_VERTEX = 1'b1
	} cmd_t;

	typedef struct packed {
		f32_t pos_x;
		f32_t pos_y;
		f32_t pos_z;
		f32_t pos_w;
	} vtx_t;

	typedef struct packed {
		f32_t a;
		f32_t b;
		f32_t c;
	} trio_t;

	typedef struct packed {
		logic                          shadow_mode;
		logic [NUM_LIGHT-1:0][WORD_W-1:0] light;
		logic [NUM_MAT-1:0][WORD_W-1:0]   mat;
	} coef_t;

	typedef struct packed {
		logic q_full;
		logic q_empty;
		logic pipe_busy;
	} bstat_t;

endpackage

// ===== rtl/vct_vtx_if.sv =====
// ----------------------------------------------------------------------------
// vct_vtx_if: input channel of the vertex clip transform
// Valid/ready handshake carrying one command item: a coefficient load or a
// vertex to transform.
// ----------------------------------------------------------------------------
interface vct_vtx_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [4:0]  coef_index;
	logic [31:0] coef_value;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [31:0] pos_w;

	modport source (
		output valid, command, coef_index, coef_value, pos_x, pos_y, pos_z, pos_w,
		input  ready
	);

	modport sink (
		input  valid, command, coef_index, coef_value, pos_x, pos_y, pos_z, pos_w,
		output ready
	);
endinterface

// ===== rtl/vct_clip_if.sv =====
// ----------------------------------------------------------------------------
// vct_clip_if: output channel of the vertex clip transform
// Valid/ready handshake carrying one clip-space position item.
// ----------------------------------------------------------------------------
interface vct_clip_if;
	logic        valid;
	logic        ready;
	logic [31:0] clip_x;
	logic [31:0] clip_y;
	logic [31:0] clip_z;
	logic [31:0] clip_w;

	modport source (
		output valid, clip_x, clip_y, clip_z, clip_w,
		input  ready
	);

	modport sink (
		input  valid, clip_x, clip_y, clip_z, clip_w,
		output ready
	);
endinterface

// ===== rtl/vct_fma.sv =====
// ----------------------------------------------------------------------------
// vct_fma: pipelined binary32 fused multiply-add
// y = a * b + c, one rounding, nearest-even, subnormals kept, canonical NaN.
// Six stages: multiply, normalize, align, add, normalize, round.
// ----------------------------------------------------------------------------
module vct_fma import vct_pkg::*; (
	input  logic clk,
	input  logic en,
	input  f32_t a,
	input  f32_t b,
	input  f32_t c,
	output f32_t y
);

	localparam logic signed [EXP_W-1:0] E_UNPACK   = EXP_W'(150);
	localparam logic signed [EXP_W-1:0] E_MIN_NORM = EXP_W'(-126);
	localparam logic signed [EXP_W-1:0] T_SUB_BASE = EXP_W'(-86);
	localparam logic signed [EXP_W-1:0] T_CLAMP    = EXP_W'(65);
	localparam logic signed [EXP_W-1:0] D_FAR      = EXP_W'(62);
	localparam logic signed [EXP_W-1:0] E_OVF      = EXP_W'(128);
	localparam logic signed [EXP_W-1:0] E_BIAS     = EXP_W'(127);

	function automatic logic [6:0] clz64(input logic [63:0] v);
		logic [6:0] n;
		logic       found;
		n = 7'd64;
		found = 1'b0;
		for (int i = 63; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 7'(63 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic signed [EXP_W-1:0] exp_of(input f32_t f);
		logic [EXP_W-1:0] raw;
		raw = {{(EXP_W-8){1'b0}}, f[30:23]};
		if (f[30:23] == 8'd0) begin
			raw = EXP_W'(1);
		end
		return raw - E_UNPACK;
	endfunction

	function automatic logic is_nan(input f32_t f);
		return f[30:0] > F32_INF[30:0];
	endfunction

	function automatic logic is_inf(input f32_t f);
		return f[30:0] == F32_INF[30:0];
	endfunction

	function automatic logic is_zero(input f32_t f);
		return f[30:0] == 31'd0;
	endfunction

	// stage 1: special cases, unpack, significand product
	logic ps, cs, spec;
	f32_t spec_v;

	always_comb begin
		ps = a[31] ^ b[31];
		cs = c[31];
		spec = 1'b1;
		spec_v = F32_QNAN;
		if (is_nan(a) || is_nan(b) || is_nan(c)) begin
			spec_v = F32_QNAN;
		end else if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) begin
			spec_v = F32_QNAN;
		end else if (is_inf(a) || is_inf(b)) begin
			spec_v = (is_inf(c) && cs != ps) ? F32_QNAN : (F32_INF | {ps, 31'd0});
		end else if (is_inf(c)) begin
			spec_v = c;
		end else if (is_zero(a) || is_zero(b)) begin
			spec_v = is_zero(c) ? {ps & cs, 31'd0} : c;
		end else begin
			spec = 1'b0;
		end
	end

	logic                    spec_s1, ps_s1, cs_s1, cz_s1;
	f32_t                    specv_s1;
	logic [47:0]             sp_s1;
	logic [23:0]             sc_s1;
	logic signed [EXP_W-1:0] ep_s1, ec_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1  <= spec;
			specv_s1 <= spec_v;
			ps_s1    <= ps;
			cs_s1    <= cs;
			cz_s1    <= is_zero(c);
			sp_s1    <= {|a[30:23], a[22:0]} * {|b[30:23], b[22:0]};
			ep_s1    <= exp_of(a) + exp_of(b);
			sc_s1    <= {|c[30:23], c[22:0]};
			ec_s1    <= exp_of(c);
		end
	end

	// stage 2: leading one of both addends to bit 61
	logic [6:0] lzp, lzc;
	assign lzp = clz64({sp_s1, 16'd0});
	assign lzc = clz64({sc_s1, 40'd0});

	logic                    spec_s2, ps_s2, cs_s2, cz_s2;
	f32_t                    specv_s2;
	logic [61:0]             x_s2, y_s2;
	logic signed [EXP_W-1:0] ex_s2, ey_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s2  <= spec_s1;
			specv_s2 <= specv_s1;
			ps_s2    <= ps_s1;
			cs_s2    <= cs_s1;
			cz_s2    <= cz_s1;
			x_s2     <= {sp_s1, 14'd0} << lzp;
			ex_s2    <= ep_s1 - EXP_W'(14) - EXP_W'(lzp);
			y_s2     <= {sc_s1, 38'd0} << lzc;
			ey_s2    <= ec_s1 - EXP_W'(38) - EXP_W'(lzc);
		end
	end

	// stage 3: order by exponent, shift the smaller with a sticky jam
	logic [61:0]             bx, sm, ya;
	logic signed [EXP_W-1:0] bex, d;
	logic                    sbx, ssm;

	always_comb begin
		if (cz_s2 || ey_s2 <= ex_s2) begin
			bx = x_s2;  bex = ex_s2; sbx = ps_s2;
			sm = y_s2;  ssm = cs_s2;
			d  = ex_s2 - ey_s2;
		end else begin
			bx = y_s2;  bex = ey_s2; sbx = cs_s2;
			sm = x_s2;  ssm = ps_s2;
			d  = ey_s2 - ex_s2;
		end
		if (cz_s2) begin
			ya  = 62'd0;
			ssm = ps_s2;
		end else if (d > D_FAR) begin
			ya = 62'd1;
		end else begin
			ya = (sm >> d[5:0]) | 62'(|(sm & ~({62{1'b1}} << d[5:0])));
		end
	end

	logic                    spec_s3, sx_s3, sy_s3;
	f32_t                    specv_s3;
	logic [61:0]             x_s3, y_s3;
	logic signed [EXP_W-1:0] ex_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s3  <= spec_s2;
			specv_s3 <= specv_s2;
			sx_s3    <= sbx;
			sy_s3    <= ssm;
			x_s3     <= bx;
			y_s3     <= ya;
			ex_s3    <= bex;
		end
	end

	// stage 4: magnitude add or subtract
	logic [62:0] sum;
	logic        sgn;

	always_comb begin
		if (sx_s3 == sy_s3) begin
			sum = {1'b0, x_s3} + {1'b0, y_s3};
			sgn = sx_s3;
		end else if (x_s3 >= y_s3) begin
			sum = {1'b0, x_s3 - y_s3};
			sgn = sx_s3;
		end else begin
			sum = {1'b0, y_s3 - x_s3};
			sgn = sy_s3;
		end
	end

	logic                    spec_s4, sgn_s4;
	f32_t                    specv_s4;
	logic [62:0]             s_s4;
	logic signed [EXP_W-1:0] ex_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s4  <= spec_s3;
			specv_s4 <= specv_s3;
			sgn_s4   <= sgn;
			s_s4     <= sum;
			ex_s4    <= ex_s3;
		end
	end

	// stage 5: leading one to bit 63, exponent of the leading one
	logic [6:0] lzs;
	assign lzs = clz64({1'b0, s_s4});

	logic                    spec_s5, sgn_s5, zero_s5;
	f32_t                    specv_s5;
	logic [63:0]             n_s5;
	logic signed [EXP_W-1:0] e_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s5  <= spec_s4;
			specv_s5 <= specv_s4;
			sgn_s5   <= sgn_s4;
			zero_s5  <= s_s4 == 63'd0;
			n_s5     <= {1'b0, s_s4} << lzs;
			e_s5     <= ex_s4 + EXP_W'(63) - EXP_W'(lzs);
		end
	end

	// stage 6: round to nearest even, subnormal and overflow handling
	logic                    normal, guard, stick, up;
	logic signed [EXP_W-1:0] tsub, eo, ebias;
	logic [6:0]              t, tm1;
	logic [63:0]             kept;
	logic [24:0]             m;
	f32_t                    res;

	always_comb begin
		normal = e_s5 >= E_MIN_NORM;
		tsub   = T_SUB_BASE - e_s5;
		if (normal) begin
			t = 7'd40;
		end else if (tsub > T_CLAMP) begin
			t = 7'd65;
		end else begin
			t = tsub[6:0];
		end
		tm1   = t - 7'd1;
		kept  = n_s5 >> t;
		guard = (t <= 7'd64) ? n_s5[tm1[5:0]] : 1'b0;
		stick = |(n_s5 & ~({64{1'b1}} << tm1));
		up    = guard & (stick | kept[0]);
		m     = kept[24:0] + 25'(up);
		eo    = e_s5 + EXP_W'(m[24]);
		ebias = eo + E_BIAS;
		if (!normal) begin
			res = {sgn_s5, 7'd0, m[23:0]};
		end else if (eo >= E_OVF) begin
			res = F32_INF | {sgn_s5, 31'd0};
		end else begin
			res = {sgn_s5, ebias[7:0], m[24] ? 23'd0 : m[22:0]};
		end
		if (spec_s5) begin
			res = specv_s5;
		end else if (zero_s5) begin
			res = 32'd0;
		end
	end

	f32_t y_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			y_s6 <= res;
		end
	end

	assign y = y_s6;

endmodule

// ===== rtl/vct_queue.sv =====
// ----------------------------------------------------------------------------
// vct_queue: short vertex queue between front and back
// Small register FIFO; lets the front keep taking vertices while the back
// is stalled by the receiver.
// ----------------------------------------------------------------------------
module vct_queue import vct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  vtx_t push_data,
	input  logic pop,
	output vtx_t pop_data,
	output logic full,
	output logic empty
);

	vtx_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
		end
	end

endmodule

// ===== rtl/vct_front.sv =====
// ----------------------------------------------------------------------------
// vct_front: command intake and coefficient storage
// Takes input items, writes coefficient loads into storage, pushes vertex
// items into the queue and holds the shadow mode register.
// ----------------------------------------------------------------------------
module vct_front import vct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	vct_vtx_if.sink    vertex,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  bstat_t     bstat,
	output logic       push,
	output vtx_t       push_data,
	output coef_t      coefs
);

	cmd_t cmd;
	logic accept, idle;

	logic [NUM_MAT-1:0][WORD_W-1:0]   mat_q;
	logic [NUM_LIGHT-1:0][WORD_W-1:0] light_q;
	logic                             shadow_q;
	logic [IDX_W-1:0]                 lidx;

	assign cmd  = cmd_t'(vertex.command);
	// a load must not reach vertices still in flight, so it waits for the back to drain
	assign idle = bstat.q_empty & ~bstat.pipe_busy;

	always_comb begin
		unique case (cmd)
			CMD_VERTEX: vertex.ready = ~bstat.q_full;
			CMD_LOAD:   vertex.ready = idle;
			default:    vertex.ready = 1'b0;
		endcase
	end

	assign accept = vertex.valid & vertex.ready;
	assign push   = accept & (cmd == CMD_VERTEX);
	assign lidx   = vertex.coef_index - IDX_LIGHT_BASE;

	assign push_data.pos_x = vertex.pos_x;
	assign push_data.pos_y = vertex.pos_y;
	assign push_data.pos_z = vertex.pos_z;
	assign push_data.pos_w = vertex.pos_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q    <= '0;
			light_q  <= '0;
			shadow_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				shadow_q <= cfg_wdata;
			end
			if (accept && cmd == CMD_LOAD) begin
				if (vertex.coef_index < IDX_LIGHT_BASE) begin
					mat_q[vertex.coef_index[3:0]] <= vertex.coef_value;
				end else if (vertex.coef_index < IDX_END) begin
					light_q[lidx[1:0]] <= vertex.coef_value;
				end
			end
		end
	end

	assign coefs.mat         = mat_q;
	assign coefs.light       = light_q;
	assign coefs.shadow_mode = shadow_q;

endmodule

// ===== rtl/vct_back.sv =====
// ----------------------------------------------------------------------------
// vct_back: transform pipeline and output register
// Eight levels of fused multiply-adds: shadow extrusion, four-term row
// chains, depth remap. Whole pipeline advances when the output slot frees.
// ----------------------------------------------------------------------------
module vct_back import vct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  coef_t      coefs,
	input  vtx_t       pop_data,
	input  logic       q_empty,
	output logic       pop,
	output logic       pipe_busy,
	vct_clip_if.source clip
);

	logic                  adv;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic                  out_valid_q;
	f32_t                  cx_q, cy_q, cz_q, cw_q;

	assign adv       = ~out_valid_q | clip.ready;
	assign pop       = adv & ~q_empty;
	assign pipe_busy = |vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[PIPE_DEPTH-2:0], pop};
			out_valid_q <= vld_q[PIPE_DEPTH-1];
		end
	end

	// level 0: 1 - w
	f32_t away;
	vct_fma u_away (.clk, .en(adv), .a(F32_NEG_ONE), .b(pop_data.pos_w), .c(F32_ONE), .y(away));

	vtx_t d0_q [FMA_LAT];
	vtx_t d1_q [FMA_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			d0_q[0] <= pop_data;
			d1_q[0] <= d0_q[FMA_LAT-1];
			for (int i = 1; i < FMA_LAT; i++) begin
				d0_q[i] <= d0_q[i-1];
				d1_q[i] <= d1_q[i-1];
			end
		end
	end

	// level 1: p - L * (1 - w)
	f32_t ex_x, ex_y, ex_z;
	vct_fma u_ext_x (.clk, .en(adv), .a(coefs.light[0] ^ F32_SIGN), .b(away),
		.c(d0_q[FMA_LAT-1].pos_x), .y(ex_x));
	vct_fma u_ext_y (.clk, .en(adv), .a(coefs.light[1] ^ F32_SIGN), .b(away),
		.c(d0_q[FMA_LAT-1].pos_y), .y(ex_y));
	vct_fma u_ext_z (.clk, .en(adv), .a(coefs.light[2] ^ F32_SIGN), .b(away),
		.c(d0_q[FMA_LAT-1].pos_z), .y(ex_z));

	f32_t px1, py1, pz1, pw1;
	assign px1 = coefs.shadow_mode ? ex_x : d1_q[FMA_LAT-1].pos_x;
	assign py1 = coefs.shadow_mode ? ex_y : d1_q[FMA_LAT-1].pos_y;
	assign pz1 = coefs.shadow_mode ? ex_z : d1_q[FMA_LAT-1].pos_z;
	assign pw1 = coefs.shadow_mode ? d1_q[FMA_LAT-1].pos_w : F32_ONE;

	// y, z, w wait for their turn in the row chains
	trio_t dp_q [3*FMA_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			dp_q[0] <= '{a: py1, b: pz1, c: pw1};
			for (int i = 1; i < 3*FMA_LAT; i++) begin
				dp_q[i] <= dp_q[i-1];
			end
		end
	end

	f32_t bsel [4];
	assign bsel[0] = px1;
	assign bsel[1] = dp_q[FMA_LAT-1].a;
	assign bsel[2] = dp_q[2*FMA_LAT-1].b;
	assign bsel[3] = dp_q[3*FMA_LAT-1].c;

	// levels 2..5: each row is a chain of four fused multiply-adds
	f32_t acc [4][4];

	for (genvar k = 0; k < 4; k++) begin : g_term
		for (genvar r = 0; r < 4; r++) begin : g_row
			f32_t addend;
			if (k == 0) begin : g_first
				assign addend = F32_NEG_ZERO;
			end else begin : g_next
				assign addend = acc[k-1][r];
			end
			vct_fma u_fma (.clk, .en(adv), .a(coefs.mat[4*k+r]), .b(bsel[k]),
				.c(addend), .y(acc[k][r]));
		end
	end

	// level 6: z + w, level 7: times one half
	f32_t zsum, zhalf;
	vct_fma u_zsum (.clk, .en(adv), .a(acc[3][2]), .b(F32_ONE), .c(acc[3][3]), .y(zsum));
	vct_fma u_zhalf (.clk, .en(adv), .a(zsum), .b(F32_HALF), .c(F32_NEG_ZERO), .y(zhalf));

	trio_t dc_q [2*FMA_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			dc_q[0] <= '{a: acc[3][0], b: acc[3][1], c: acc[3][3]};
			for (int i = 1; i < 2*FMA_LAT; i++) begin
				dc_q[i] <= dc_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_q <= dc_q[2*FMA_LAT-1].a;
			cy_q <= dc_q[2*FMA_LAT-1].b;
			cw_q <= dc_q[2*FMA_LAT-1].c;
			cz_q <= zhalf;
		end
	end

	assign clip.valid  = out_valid_q;
	assign clip.clip_x = cx_q;
	assign clip.clip_y = cy_q;
	assign clip.clip_z = cz_q;
	assign clip.clip_w = cw_q;

endmodule

// ===== rtl/vertex_clip_transform.sv =====
// ----------------------------------------------------------------------------
// vertex_clip_transform: object space to clip space in binary32
// Coefficient loads and vertex transforms on one valid/ready channel,
// clip positions on another.
// ----------------------------------------------------------------------------
// Usage:
//  - vertex channel: command 0 loads coef_index/coef_value (0-15 matrix,
//    column-major; 16-18 light origin; higher indexes are dropped),
//    command 1 transforms pos_x..pos_w. Loads give no item on clip.
//  - clip channel: one item per vertex, in order.
//  - cfg_we/cfg_wdata write shadow_mode; write only while the block is idle.
//  - Path: 8 levels of a 6-stage fused multiply-add, then the output
//    register, from vertex accept to clip valid.
//  - Throughput: one vertex per cycle while clip.ready stays high. A load
//    is held off until every vertex ahead of it has left the pipeline,
//    so group loads ahead of vertex runs.
//  - Reset clears the coefficients, shadow_mode, the queue and all valids.
//  - clip.valid high with clip.ready low freezes the pipeline; a 4-entry
//    queue keeps taking vertices until it fills, then vertex.ready drops.
// ----------------------------------------------------------------------------
module vertex_clip_transform import vct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	vct_vtx_if.sink    vertex,
	vct_clip_if.source clip
);

	bstat_t bstat;
	coef_t  coefs;
	logic   push, pop, q_full, q_empty, pipe_busy;
	vtx_t   push_data, pop_data;

	assign bstat.q_full    = q_full;
	assign bstat.q_empty   = q_empty;
	assign bstat.pipe_busy = pipe_busy;

	// intake: classifies items, applies loads, pushes vertices
	vct_front u_front (
		.clk,
		.arst_n,
		.vertex,
		.cfg_we,
		.cfg_wdata,
		.bstat,
		.push,
		.push_data,
		.coefs
	);

	// decoupling queue
	vct_queue u_queue (
		.clk,
		.arst_n,
		.push,
		.push_data,
		.pop,
		.pop_data,
		.full  (q_full),
		.empty (q_empty)
	);

	// arithmetic pipeline and output register
	vct_back u_back (
		.clk,
		.arst_n,
		.coefs,
		.pop_data,
		.q_empty,
		.pop,
		.pipe_busy,
		.clip
	);

endmodule

// ===== tb/vertex_clip_transform_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_clip_transform_tb: self-checking bench for the vertex clip transform
// Streams coefficient loads and vertices through the valid/ready channels
// with random idle bursts on both sides. A bit-exact binary32 fused
// multiply-add predictor works out every clip item, checked in order.
// ----------------------------------------------------------------------------
module vertex_clip_transform_tb;
	import vct_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int DRAIN_WAIT  = 60;      // pipeline is 49 deep, loads wait it out
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		cmd_t            command;
		logic [IDX_W-1:0] coef_index;
		f32_t            coef_value;
		vtx_t            pos;
	} cmd_item_t;

	typedef struct {
		f32_t x;
		f32_t y;
		f32_t z;
		f32_t w;
	} clip_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	vct_vtx_if  vtx_ch ();
	vct_clip_if clip_ch ();

	vertex_clip_transform u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.vertex    (vtx_ch),
		.clip      (clip_ch)
	);

	// bench copy of the block's storage
	f32_t mat_words [NUM_MAT];
	f32_t light_words [NUM_LIGHT];
	logic shadow_on;

	cmd_item_t  pending_cmds [$];
	clip_item_t clip_expect [$];

	int   errors;
	int   cycles;
	int   send_gap;
	int   recv_gap;
	logic quiet;        // no idling in the closing stretch
	logic vtx_taken;

	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------
	// binary32 arithmetic, round to nearest even, subnormals kept
	// ------------------------------------------------------------------
	function automatic int top_bit(input longint unsigned v);
		int n;
		n = 0;
		while (n < 63 && (v >> (n + 1)) != 0)
			n++;
		return n;
	endfunction

	function automatic f32_t round_to_f32(input f32_t sgn, input longint unsigned sig,
			input int ex);
		int n;
		int e;
		int shift;
		logic normal;
		longint unsigned m;
		longint unsigned kept;
		longint unsigned rem;
		longint unsigned half;
		n = top_bit(sig);
		e = n + ex;
		normal = (e >= -126);
		shift = normal ? n - 23 : -149 - ex;
		if (shift <= 0) begin
			m = sig << (-shift);
		end else begin
			if (shift >= 64) begin
				kept = 0;
				if (shift == 64) begin
					rem = sig;
					half = 64'h8000_0000_0000_0000;
				end else begin
					rem = 1;
					half = 2;
				end
			end else begin
				kept = sig >> shift;
				rem = sig & ((64'd1 << shift) - 1);
				half = 64'd1 << (shift - 1);
			end
			m = kept;
			if (rem > half || (rem == half && kept[0]))
				m++;
		end
		if (!normal)
			return sgn | f32_t'(m);
		if (m == (64'd1 << 24)) begin
			m >>= 1;
			e++;
		end
		if (e + 127 >= 255)
			return sgn | F32_INF;
		return sgn | (f32_t'(e + 127) << 23) | (f32_t'(m) & 32'h007F_FFFF);
	endfunction

	function automatic void split_f32(input f32_t f, output longint unsigned sig,
			output int ex);
		if (f[30:23] == 0) begin
			sig = f[22:0];
			ex = -149;
		end else begin
			sig = {1'b1, f[22:0]};
			ex = int'(f[30:23]) - 150;
		end
	endfunction

	function automatic logic f_nan(input f32_t f);
		return f[30:0] > F32_INF[30:0];
	endfunction

	function automatic logic f_inf(input f32_t f);
		return f[30:0] == F32_INF[30:0];
	endfunction

	function automatic logic f_zero(input f32_t f);
		return f[30:0] == 0;
	endfunction

	// a * b + c, single rounding
	function automatic f32_t fused_mul_add(input f32_t a, input f32_t b, input f32_t c);
		f32_t ps, cs, sx, sy, sgn;
		longint unsigned sa, sb, sc, sp, x, y, s, t, lost;
		int ea, eb, ec, ep, ex, ey, d, n;
		ps = (a ^ b) & F32_SIGN;
		cs = c & F32_SIGN;
		if (f_nan(a) || f_nan(b) || f_nan(c))
			return F32_QNAN;
		if ((f_inf(a) && f_zero(b)) || (f_inf(b) && f_zero(a)))
			return F32_QNAN;
		if (f_inf(a) || f_inf(b)) begin
			if (f_inf(c) && cs != ps)
				return F32_QNAN;
			return ps | F32_INF;
		end
		if (f_inf(c))
			return c;
		if (f_zero(a) || f_zero(b))
			return f_zero(c) ? (ps & cs) : c;
		split_f32(a, sa, ea);
		split_f32(b, sb, eb);
		sp = sa * sb;
		ep = ea + eb;
		if (f_zero(c))
			return round_to_f32(ps, sp, ep);
		split_f32(c, sc, ec);
		// line both up with the leading one at bit 61
		n = top_bit(sp);
		sp <<= (61 - n);
		ep -= (61 - n);
		n = top_bit(sc);
		sc <<= (61 - n);
		ec -= (61 - n);
		x = sp; ex = ep; sx = ps;
		y = sc; ey = ec; sy = cs;
		if (ey > ex) begin
			t = x; x = y; y = t;
			d = ex; ex = ey; ey = d;
			sgn = sx; sx = sy; sy = sgn;
		end
		d = ex - ey;
		if (d >= 63) begin
			y = 1;
		end else if (d > 0) begin
			lost = y & ((64'd1 << d) - 1);
			y = (y >> d) | (lost != 0);
		end
		if (sx == sy) begin
			s = x + y;
			sgn = sx;
		end else if (x >= y) begin
			s = x - y;
			sgn = sx;
		end else begin
			s = y - x;
			sgn = sy;
		end
		if (s == 0)
			return '0;  // opposite-sign exact zero is +0
		return round_to_f32(sgn, s, ex);
	endfunction

	function automatic f32_t clip_row(input int r, input vtx_t p);
		f32_t acc;
		acc = fused_mul_add(mat_words[r], p.pos_x, F32_NEG_ZERO);
		acc = fused_mul_add(mat_words[4 + r], p.pos_y, acc);
		acc = fused_mul_add(mat_words[8 + r], p.pos_z, acc);
		return fused_mul_add(mat_words[12 + r], p.pos_w, acc);
	endfunction

	// apply one accepted item to the bench state, queue the clip item it causes
	function automatic void transform_item(input cmd_item_t it);
		vtx_t p;
		f32_t away;
		clip_item_t res;
		logic [IDX_W-1:0] lidx;
		if (it.command == CMD_LOAD) begin
			lidx = it.coef_index - IDX_LIGHT_BASE;
			if (it.coef_index < IDX_LIGHT_BASE)
				mat_words[it.coef_index[3:0]] = it.coef_value;
			else if (it.coef_index < IDX_END)
				light_words[lidx[1:0]] = it.coef_value;
			return;
		end
		p = it.pos;
		if (shadow_on) begin
			// push away from the light by (1 - w)
			away = fused_mul_add(F32_NEG_ONE, p.pos_w, F32_ONE);
			p.pos_x = fused_mul_add(light_words[0] ^ F32_SIGN, away, p.pos_x);
			p.pos_y = fused_mul_add(light_words[1] ^ F32_SIGN, away, p.pos_y);
			p.pos_z = fused_mul_add(light_words[2] ^ F32_SIGN, away, p.pos_z);
		end else begin
			p.pos_w = F32_ONE;
		end
		res.x = clip_row(0, p);
		res.y = clip_row(1, p);
		res.z = clip_row(2, p);
		res.w = clip_row(3, p);
		// depth remap (z + w) * 0.5, two roundings
		res.z = fused_mul_add(fused_mul_add(res.z, F32_ONE, res.w), F32_HALF,
			F32_NEG_ZERO);
		clip_expect.push_back(res);
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic f32_t rand_f32();
		f32_t v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v[30:23] = 8'($urandom_range(112, 140));  // everyday range
			4:          ;                                         // raw bits
			5: begin
				case ($urandom_range(0, 5))
					0: v = '0;
					1: v = F32_SIGN;
					2: v = F32_INF | (v & F32_SIGN);
					3: v = v | F32_INF;                     // NaN, or inf if frac 0
					4: v = F32_ONE;
					default: v = F32_NEG_ONE;
				endcase
			end
			6:          v[30:23] = 8'($urandom_range(0, 1));    // subnormal / tiny
			7:          v[30:23] = 8'($urandom_range(235, 254)); // near overflow
			default:    v[30:23] = 8'($urandom_range(120, 132));
		endcase
		return v;
	endfunction

	function automatic void push_load(input int idx, input f32_t val);
		cmd_item_t it;
		it.command = CMD_LOAD;
		it.coef_index = IDX_W'(idx);
		it.coef_value = val;
		it.pos = {$urandom, $urandom, $urandom, $urandom};  // ignored on a load
		pending_cmds.push_back(it);
	endfunction

	function automatic void push_vertex(input f32_t x, input f32_t y, input f32_t z,
			input f32_t w);
		cmd_item_t it;
		it.command = CMD_VERTEX;
		it.coef_index = IDX_W'($urandom);  // ignored on a vertex
		it.coef_value = $urandom;
		it.pos = {x, y, z, w};
		pending_cmds.push_back(it);
	endfunction

	// full coefficient set, occasionally with a stray out-of-range load mixed in
	function automatic void push_coef_set();
		for (int i = 0; i < NUM_MAT + NUM_LIGHT; i++) begin
			push_load(i, rand_f32());
			if ($urandom_range(0, 15) == 0)
				push_load($urandom_range(int'(IDX_END), 31), $urandom);
		end
	endfunction

	function automatic void push_random_run(input int count);
		int left;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 5) == 0) begin
				push_coef_set();
				left -= NUM_MAT + NUM_LIGHT;
			end else if ($urandom_range(0, 3) == 0) begin
				push_load($urandom_range(0, int'(IDX_END) - 1), rand_f32());
				left--;
			end else begin
				push_vertex(rand_f32(), rand_f32(), rand_f32(), rand_f32());
				left--;
			end
		end
	endfunction

	// everything sent, every clip item back, pipeline drained
	task automatic settle();
		while (pending_cmds.size() != 0 || vtx_ch.valid || clip_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_shadow(input logic on);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= on;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_on = on;
	endtask

	// ------------------------------------------------------------------
	// vertex driver: changes at the falling edge, idles in random bursts
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!vtx_ch.valid || vtx_taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				vtx_ch.valid <= 1'b0;
			end else if (!quiet && pending_cmds.size() != 0
					&& $urandom_range(0, 6) == 0) begin
				send_gap <= $urandom_range(0, 5);
				vtx_ch.valid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				vtx_ch.valid      <= 1'b1;
				vtx_ch.command    <= pending_cmds[0].command;
				vtx_ch.coef_index <= pending_cmds[0].coef_index;
				vtx_ch.coef_value <= pending_cmds[0].coef_value;
				vtx_ch.pos_x      <= pending_cmds[0].pos.pos_x;
				vtx_ch.pos_y      <= pending_cmds[0].pos.pos_y;
				vtx_ch.pos_z      <= pending_cmds[0].pos.pos_z;
				vtx_ch.pos_w      <= pending_cmds[0].pos.pos_w;
				void'(pending_cmds.pop_front());
			end else begin
				vtx_ch.valid <= 1'b0;
			end
		end
	end

	// clip side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				clip_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				recv_gap <= $urandom_range(0, 5);
				clip_ch.ready <= 1'b0;
			end else begin
				clip_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: predict on input accept, check on output accept
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		cmd_item_t  seen;
		clip_item_t want;
		if (!arst_n) begin
			vtx_taken <= 1'b0;
		end else begin
			cycles++;
			vtx_taken <= vtx_ch.valid && vtx_ch.ready;
			if (vtx_ch.valid && vtx_ch.ready) begin
				seen.command    = cmd_t'(vtx_ch.command);
				seen.coef_index = vtx_ch.coef_index;
				seen.coef_value = vtx_ch.coef_value;
				seen.pos        = {vtx_ch.pos_x, vtx_ch.pos_y, vtx_ch.pos_z, vtx_ch.pos_w};
				transform_item(seen);
			end
			if (clip_ch.valid && clip_ch.ready) begin
				if (clip_expect.size() == 0) begin
					$display("%0t: clip item with none expected, got %h %h %h %h", $time,
						clip_ch.clip_x, clip_ch.clip_y, clip_ch.clip_z, clip_ch.clip_w);
					errors++;
				end else begin
					want = clip_expect.pop_front();
					if (clip_ch.clip_x !== want.x) begin
						$display("%0t: clip_x expected %h got %h", $time, want.x, clip_ch.clip_x);
						errors++;
					end
					if (clip_ch.clip_y !== want.y) begin
						$display("%0t: clip_y expected %h got %h", $time, want.y, clip_ch.clip_y);
						errors++;
					end
					if (clip_ch.clip_z !== want.z) begin
						$display("%0t: clip_z expected %h got %h", $time, want.z, clip_ch.clip_z);
						errors++;
					end
					if (clip_ch.clip_w !== want.w) begin
						$display("%0t: clip_w expected %h got %h", $time, want.w, clip_ch.clip_w);
						errors++;
					end
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		vtx_ch.valid = 1'b0;
		vtx_ch.command = CMD_LOAD;
		vtx_ch.coef_index = '0;
		vtx_ch.coef_value = '0;
		vtx_ch.pos_x = '0;
		vtx_ch.pos_y = '0;
		vtx_ch.pos_z = '0;
		vtx_ch.pos_w = '0;
		clip_ch.ready = 1'b0;
		errors = 0;
		cycles = 0;
		send_gap = 0;
		recv_gap = 0;
		quiet = 1'b0;
		shadow_on = 1'b0;
		foreach (mat_words[i]) mat_words[i] = '0;
		foreach (light_words[i]) light_words[i] = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_shadow(1'b0);

		// directed: zero matrix first, then identity-ish with light set
		push_vertex(F32_ONE, F32_NEG_ONE, 32'h7F7F_FFFF, F32_ONE);
		for (int i = 0; i < NUM_MAT; i++)
			push_load(i, (i % 5 == 0) ? F32_ONE : '0);
		push_load(16, 32'h4000_0000);
		push_load(17, 32'hC040_0000);
		push_load(18, 32'h0000_0001);
		push_load(19, 32'hFFFF_FFFF);                       // dropped
		push_load(31, 32'h3F80_0000);                       // dropped
		push_vertex('0, F32_SIGN, 32'h0000_0001, 32'h8000_0001);
		push_vertex(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, '0);     // overflow
		push_vertex(F32_INF, '0, 32'hFF80_0000, F32_INF);                // inf * 0
		push_vertex(32'h7FC1_2345, 32'hFFFF_FFFF, F32_ONE, 32'h0080_0000); // NaN in
		push_vertex(F32_ONE, F32_NEG_ONE, '0, F32_NEG_ONE);              // exact zero
		settle();

		// shadow on, same matrix: w = 0, w = 1, inf and NaN w
		write_shadow(1'b1);
		push_vertex(F32_ONE, F32_ONE, F32_ONE, '0);
		push_vertex(F32_ONE, F32_ONE, F32_ONE, F32_ONE);
		push_vertex(32'h4120_0000, F32_SIGN, 32'h0000_0001, F32_INF);
		push_vertex(F32_ONE, F32_ONE, F32_ONE, 32'hFFC0_0001);
		settle();

		// random phases across both modes
		write_shadow(1'b0);
		push_random_run(450);
		settle();
		write_shadow(1'b1);
		push_random_run(550);
		settle();
		write_shadow(1'b0);
		push_random_run(450);
		settle();
		write_shadow(1'b1);
		push_random_run(300);
		while (pending_cmds.size() != 0)
			@(posedge clk);
		quiet = 1'b1;
		push_random_run(200);
		settle();

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/vct_pkg.sv
rtl/vct_vtx_if.sv
rtl/vct_clip_if.sv
rtl/vct_fma.sv
rtl/vct_queue.sv
rtl/vct_front.sv
rtl/vct_back.sv
rtl/vertex_clip_transform.sv
tb/vertex_clip_transform_tb.sv
